// ===== sv/wmlr_pkg.sv =====
// ----------------------------------------------------------------------------
// wmlr_pkg
// Shared types, constants and helpers of the windowed max over lag range unit.
// ----------------------------------------------------------------------------
`default_nettype none

package wmlr_pkg;

    localparam int FRAME_LEN   = 1024;
    localparam int MAX_HALF    = 16;
    localparam int CELL_COUNT  = 2 * MAX_HALF;

    localparam int SAMPLE_W    = 24;
    localparam int LAG_W       = 10;
    localparam int HALF_W      = 5;
    localparam int POS_W       = $clog2(FRAME_LEN);
    localparam int CELL_IDX_W  = $clog2(CELL_COUNT);

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;

    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 40;

    localparam logic PAIR_ON   = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_HALF_WINDOW  = 2'd0,
        CFG_RANGE_LOW    = 2'd1,
        CFG_RANGE_HIGH   = 2'd2,
        CFG_PAIR_ENABLED = 2'd3
    } cfg_index_t;

    // running max step: a frame start drops everything seen before
    function automatic sample_t win_max(input sample_t sample, input sample_t prev_max,
                                        input logic frame_start);
        sample_t r;
        if (frame_start || (sample > prev_max)) begin
            r = sample;
        end else begin
            r = prev_max;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/wmlr_cell.sv =====
// ----------------------------------------------------------------------------
// wmlr_cell
// One cell of the running-max chain: holds the max of the last k+1 samples.
// ----------------------------------------------------------------------------
`default_nettype none

module wmlr_cell
    import wmlr_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    shift_en,
    input  wire logic    frame_start,
    input  wire sample_t sample,
    input  wire sample_t left_max,
    output sample_t      cell_max
);

    sample_t cell_max_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            cell_max_reg <= win_max(sample, left_max, frame_start);
        end
    end

    assign cell_max = cell_max_reg;

endmodule

`default_nettype wire

// ===== sv/windowed_max_over_lag_range_unit.sv =====
// ----------------------------------------------------------------------------
// windowed_max_over_lag_range_unit
// Sliding-window maximum over one correlation frame for a lag range.
// ----------------------------------------------------------------------------
// One sample is taken every cycle while the master side does not stall;
// its result, if any, shows on the master side the cycle after the request
// is accepted. A chain of 32 cells, each doing one compare per sample, keeps
// the max of the last 1..32 samples of the frame; the result is the new
// sample against the cell picked by 2*half_window-1. half_window above 16
// acts as 16. Configuration must be written while the unit is idle.
`default_nettype none

module windowed_max_over_lag_range_unit
    import wmlr_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,

    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [S_TDATA_W-1:0]   s_axis_tdata,  // [23:0] sample_value
    input  wire logic                   s_axis_tlast,  // frame_end

    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [M_TDATA_W-1:0]        m_axis_tdata,  // [9:0] lag_index,
                                                       // [33:10] max_value, pad
    output logic                        m_axis_tlast   // last_lag
);

    logic [HALF_W-1:0] half_window_reg;
    logic [LAG_W-1:0]  range_low_reg;
    logic [LAG_W-1:0]  range_high_reg;
    logic              pair_enabled_reg;

    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;

    logic              m_valid_reg;
    logic              m_valid_next;
    logic [LAG_W-1:0]  m_lag_reg;
    sample_t           m_max_reg;
    logic              m_last_reg;

    logic              accept;
    logic              frame_start;
    sample_t           sample;
    logic [HALF_W-1:0] h;
    logic [HALF_W:0]   h2m1;
    logic [CELL_IDX_W-1:0] sel_idx;
    logic [POS_W-1:0]  lag;
    logic              produce;
    sample_t           result;

    sample_t           chain [CELL_COUNT];

    assign sample        = sample_t'(s_axis_tdata[SAMPLE_W-1:0]);
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign frame_start   = (pos_reg == '0);

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_window_reg  <= '0;
            range_low_reg    <= '0;
            range_high_reg   <= '1;
            pair_enabled_reg <= PAIR_ON;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                CFG_HALF_WINDOW:  half_window_reg  <= cfg_data[HALF_W-1:0];
                CFG_RANGE_LOW:    range_low_reg    <= cfg_data[LAG_W-1:0];
                CFG_RANGE_HIGH:   range_high_reg   <= cfg_data[LAG_W-1:0];
                CFG_PAIR_ENABLED: pair_enabled_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // running-max chain
    genvar k;
    generate
        for (k = 0; k < CELL_COUNT; k++) begin : g_cell
            wmlr_cell u_cell (
                .aclk        (aclk),
                .shift_en    (accept),
                .frame_start (frame_start),
                .sample      (sample),
                .left_max    ((k == 0) ? sample : chain[(k == 0) ? 0 : k-1]),
                .cell_max    (chain[k])
            );
        end
    endgenerate

    always_comb begin
        h       = (half_window_reg > HALF_W'(MAX_HALF)) ? HALF_W'(MAX_HALF)
                                                        : half_window_reg;
        h2m1    = {h, 1'b0} - (HALF_W+1)'(1);
        sel_idx = h2m1[CELL_IDX_W-1:0];
        lag     = pos_reg - POS_W'(h);
        produce = (pair_enabled_reg == PAIR_ON) && (pos_reg >= POS_W'(h))
                  && (LAG_W'(lag) >= range_low_reg) && (LAG_W'(lag) <= range_high_reg);
        if (h == '0) begin
            result = sample;
        end else begin
            result = win_max(sample, chain[sel_idx], frame_start);
        end
        if (s_axis_tlast || (pos_reg == POS_W'(FRAME_LEN - 1))) begin
            pos_next = '0;
        end else begin
            pos_next = pos_reg + POS_W'(1);
        end
        if (accept) begin
            m_valid_next = produce;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                pos_reg <= pos_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && produce) begin
            m_lag_reg  <= LAG_W'(lag);
            m_max_reg  <= result;
            m_last_reg <= (LAG_W'(lag) == range_high_reg);
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {(M_TDATA_W-SAMPLE_W-LAG_W)'(0), m_max_reg, m_lag_reg};
    assign m_axis_tlast  = m_last_reg;

endmodule

`default_nettype wire
